>>> src/arc_pkg.sv
// Shared types and constants for the box region classifier.
`timescale 1ns / 1ps

package arc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TUSER_W         = 2;
    localparam int OUT_TDATA_W     = 8;

    typedef enum logic [1:0] {
        OP_POINT  = 2'd0,
        OP_BOX    = 2'd1,
        OP_SPHERE = 2'd2,
        OP_FAST   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        VERDICT_OUT   = 2'd0,
        VERDICT_ISECT = 2'd1,
        VERDICT_IN    = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_reg_idx;

endpackage

>>> src/aabb_region_classifier.sv
// Five register stages (compare, partial products, square combine, distance sum,
// radius compare) carry an accepted request to its verdict on the master side.
// Throughput: one request per cycle unless a full stage is held by m_axis_tready low.
// Stages with no valid item fill even while the output waits, so bubbles close up.
// Reset (synchronous, active low) clears all stage valid bits and loads the box
// registers with an empty box (min at the largest code, max at the smallest).
`timescale 1ns / 1ps

module aabb_region_classifier #(
    parameter  int COORD_WIDTH = arc_pkg::COORD_WIDTH_DEF,
    localparam int IN_TDATA_W  = ((7 * COORD_WIDTH - 1 + 7) / 8) * 8,
    localparam int APB_DW      = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int PADDR_W     = (COORD_WIDTH > 32) ? 6 : 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // query_x, query_y, query_z, query_hi_x, query_hi_y, query_hi_z, radius
    input  logic [IN_TDATA_W-1:0]         s_axis_tdata,
    // op
    input  logic [arc_pkg::TUSER_W-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // verdict
    output logic [arc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [APB_DW-1:0]             pwdata,
    output logic [APB_DW-1:0]             prdata,
    output logic                          pready
);
    import arc_pkg::*;

    localparam int CW       = COORD_WIDTH;
    localparam int ADDR_LSB = (COORD_WIDTH > 32) ? 3 : 2;
    localparam int SW       = 2 * CW;

    // ---------------- Configuration ----------------
    logic signed [CW-1:0] r_bmin [3];
    logic signed [CW-1:0] r_bmax [3];
    logic signed [CW-1:0] rd_val;
    t_reg_idx             reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_LSB+2:ADDR_LSB]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_bmin[i] <= {1'b0, {(CW-1){1'b1}}};
                r_bmax[i] <= {1'b1, {(CW-1){1'b0}}};
            end
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MIN_X: r_bmin[0] <= pwdata[CW-1:0];
                REG_MIN_Y: r_bmin[1] <= pwdata[CW-1:0];
                REG_MIN_Z: r_bmin[2] <= pwdata[CW-1:0];
                REG_MAX_X: r_bmax[0] <= pwdata[CW-1:0];
                REG_MAX_Y: r_bmax[1] <= pwdata[CW-1:0];
                REG_MAX_Z: r_bmax[2] <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_X: rd_val = r_bmin[0];
            REG_MIN_Y: rd_val = r_bmin[1];
            REG_MIN_Z: rd_val = r_bmin[2];
            REG_MAX_X: rd_val = r_bmax[0];
            REG_MAX_Y: rd_val = r_bmax[1];
            REG_MAX_Z: rd_val = r_bmax[2];
            default:   rd_val = '0;
        endcase
        prdata = APB_DW'(rd_val);
    end

    // ---------------- Stage handshake ----------------
    logic [4:0] r_vld;
    logic [4:0] n_vld;
    logic [4:0] rdy;

    always_comb begin
        rdy[4] = !r_vld[4] | m_axis_tready;
        for (int k = 3; k >= 0; k--) begin
            rdy[k] = !r_vld[k] | rdy[k+1];
        end
        n_vld[0] = rdy[0] ? s_axis_tvalid : r_vld[0];
        for (int k = 1; k < 5; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign s_axis_tready = rdy[0];

    // ---------------- Stage 1: per-axis compares and distances ----------------
    logic signed [CW-1:0] q_lo [3];
    logic signed [CW-1:0] q_hi [3];
    logic [CW-2:0]        q_r;
    t_op                  op;
    logic [2:0]           lt_min, gt_max, hi_lt_min, hi_gt_max, ext_lo_lt, ext_hi_gt;
    logic signed [CW:0]   ext_lo [3];
    logic signed [CW:0]   ext_hi [3];
    logic signed [CW:0]   d_min  [3];
    logic signed [CW:0]   d_max  [3];
    logic [CW-1:0]        slab_gap [3];

    assign q_r = s_axis_tdata[6*CW +: CW-1];
    assign op  = t_op'(s_axis_tuser[1:0]);

    for (genvar g = 0; g < 3; g++) begin : g_axis
        assign q_lo[g] = s_axis_tdata[g*CW +: CW];
        assign q_hi[g] = s_axis_tdata[(g+3)*CW +: CW];

        assign lt_min[g]    = q_lo[g] < r_bmin[g];
        assign gt_max[g]    = q_lo[g] > r_bmax[g];
        assign hi_lt_min[g] = q_hi[g] < r_bmin[g];
        assign hi_gt_max[g] = q_hi[g] > r_bmax[g];

        assign ext_lo[g]    = {q_lo[g][CW-1], q_lo[g]} - {2'b00, q_r};
        assign ext_hi[g]    = {q_lo[g][CW-1], q_lo[g]} + {2'b00, q_r};
        assign ext_lo_lt[g] = ext_lo[g] < $signed({r_bmin[g][CW-1], r_bmin[g]});
        assign ext_hi_gt[g] = ext_hi[g] > $signed({r_bmax[g][CW-1], r_bmax[g]});

        // The distance to the slab is positive and below 2^CW when nonzero.
        assign d_min[g] = {r_bmin[g][CW-1], r_bmin[g]} - {q_lo[g][CW-1], q_lo[g]};
        assign d_max[g] = {q_lo[g][CW-1], q_lo[g]} - {r_bmax[g][CW-1], r_bmax[g]};
        assign slab_gap[g] = lt_min[g] ? d_min[g][CW-1:0] :
                             gt_max[g] ? d_max[g][CW-1:0] : '0;
    end

    t_verdict pre;
    logic     is_sph;

    always_comb begin
        is_sph = 1'b0;
        case (op)
            OP_POINT:  pre = |(lt_min | gt_max) ? VERDICT_OUT : VERDICT_IN;
            OP_BOX:    pre = |(hi_lt_min | gt_max) ? VERDICT_OUT :
                             |(lt_min | hi_gt_max) ? VERDICT_ISECT : VERDICT_IN;
            OP_SPHERE: begin
                is_sph = 1'b1;
                pre    = |(ext_lo_lt | ext_hi_gt) ? VERDICT_ISECT : VERDICT_IN;
            end
            OP_FAST:   pre = |(hi_lt_min | gt_max) ? VERDICT_OUT : VERDICT_IN;
            default:   pre = VERDICT_OUT;
        endcase
    end

    logic [CW-1:0] r_s1_dist [3];
    logic [CW-1:0] r_s1_r;
    t_verdict      r_s1_pre, r_s2_pre, r_s3_pre, r_s4_pre;
    logic          r_s1_sph, r_s2_sph, r_s3_sph, r_s4_sph;

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_dist[i] <= slab_gap[i];
            end
            r_s1_r   <= {1'b0, q_r};
            r_s1_pre <= pre;
            r_s1_sph <= is_sph;
        end
    end

    // ---------------- Stages 2 and 3: squares ----------------
    logic [SW-1:0] sq [3];
    logic [SW-1:0] sq_r;

    for (genvar g = 0; g < 3; g++) begin : g_sq
        arc_sq_unit #(.COORD_WIDTH(COORD_WIDTH)) u_sq (
            .i_clk   (i_clk),
            .i_en_pp (rdy[1]),
            .i_en_sq (rdy[2]),
            .i_a     (r_s1_dist[g]),
            .o_sq    (sq[g])
        );
    end

    arc_sq_unit #(.COORD_WIDTH(COORD_WIDTH)) u_sq_r (
        .i_clk   (i_clk),
        .i_en_pp (rdy[1]),
        .i_en_sq (rdy[2]),
        .i_a     (r_s1_r),
        .o_sq    (sq_r)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s2_pre <= r_s1_pre;
            r_s2_sph <= r_s1_sph;
        end
        if (rdy[2]) begin
            r_s3_pre <= r_s2_pre;
            r_s3_sph <= r_s2_sph;
        end
    end

    // ---------------- Stage 4: squared distance sum ----------------
    logic [SW+1:0] r_s4_d2, n_s4_d2;
    logic [SW-1:0] r_s4_r2;

    assign n_s4_d2 = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_s4_d2  <= n_s4_d2;
            r_s4_r2  <= sq_r;
            r_s4_pre <= r_s3_pre;
            r_s4_sph <= r_s3_sph;
        end
    end

    // ---------------- Stage 5: radius compare and output register ----------------
    t_verdict r_verdict, n_verdict;

    always_comb begin
        if (r_s4_sph && (r_s4_d2 > {2'b00, r_s4_r2})) begin
            n_verdict = VERDICT_OUT;
        end else begin
            n_verdict = r_s4_pre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_verdict <= n_verdict;
        end
    end

    assign m_axis_tvalid = r_vld[4];
    assign m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, r_verdict};

endmodule

>>> src/arc_sq_unit.sv
// Two-stage squarer built from three half-width partial products.
`timescale 1ns / 1ps

module arc_sq_unit #(
    parameter int COORD_WIDTH = arc_pkg::COORD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_en_pp,
    input  logic                       i_en_sq,
    input  logic [COORD_WIDTH-1:0]     i_a,
    output logic [2*COORD_WIDTH-1:0]   o_sq
);
    import arc_pkg::*;

    localparam int LW = (COORD_WIDTH + 1) / 2;
    localparam int HW = COORD_WIDTH - LW;
    localparam int SW = 2 * COORD_WIDTH;

    logic [LW-1:0]          a_lo;
    logic [HW-1:0]          a_hi;
    logic [2*LW-1:0]        r_ll, n_ll;
    logic [COORD_WIDTH-1:0] r_lh, n_lh;
    logic [2*HW-1:0]        r_hh, n_hh;
    logic [SW-1:0]          r_sq, n_sq;

    assign a_lo = i_a[LW-1:0];
    assign a_hi = i_a[COORD_WIDTH-1:LW];

    always_comb begin
        n_ll = {{LW{1'b0}}, a_lo} * {{LW{1'b0}}, a_lo};
        n_lh = {{HW{1'b0}}, a_lo} * {{LW{1'b0}}, a_hi};
        n_hh = {{HW{1'b0}}, a_hi} * {{HW{1'b0}}, a_hi};
    end

    // a^2 = hh*2^(2L) + 2*lh*2^L + ll; the cross term is shifted by L+1.
    always_comb begin
        n_sq = {r_hh, {(2*LW){1'b0}}}
             + {{(HW-1){1'b0}}, r_lh, {(LW+1){1'b0}}}
             + {{(2*HW){1'b0}}, r_ll};
    end

    always_ff @(posedge i_clk) begin
        if (i_en_pp) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hh <= n_hh;
        end
        if (i_en_sq) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

>>> src/arc_checker.sv
// Port-level checker for the box region classifier, with its bind statement.
`timescale 1ns / 1ps

module arc_checker #(
    parameter  int COORD_WIDTH = arc_pkg::COORD_WIDTH_DEF,
    localparam int IN_TDATA_W  = ((7 * COORD_WIDTH - 1 + 7) / 8) * 8,
    localparam int APB_DW      = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int PADDR_W     = (COORD_WIDTH > 32) ? 6 : 5
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    // query_x, query_y, query_z, query_hi_x, query_hi_y, query_hi_z, radius
    input logic [IN_TDATA_W-1:0]           s_axis_tdata,
    // op
    input logic [arc_pkg::TUSER_W-1:0]     s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    // verdict
    input logic [arc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [PADDR_W-1:0]              paddr,
    input logic [APB_DW-1:0]               pwdata,
    input logic [APB_DW-1:0]               prdata,
    input logic                            pready
);
    import arc_pkg::*;

    localparam int ADDR_LSB = (COORD_WIDTH > 32) ? 3 : 2;

    // Reset empties every stage, so no result survives it.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // With the output register empty, every stage can move, so a request is taken.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the pipeline has room");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // A box register reads back what was last written to it.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(psel && penable && pwrite && pready)
        && psel && !pwrite && (paddr == $past(paddr))
        && (paddr[ADDR_LSB+2:ADDR_LSB] <= 3'(REG_MAX_Z))
        |-> prdata[COORD_WIDTH-1:0] == $past(pwdata[COORD_WIDTH-1:0]))
        else $error("box register readback mismatch");

endmodule

bind aabb_region_classifier arc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_arc_checker (.*);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the box region classifier.
`timescale 1ns / 1ps

module tb_top;
    import arc_pkg::*;

    localparam int          PIPE_LAT    = 5;
    localparam int          STALL_LIMIT = 2000;
    localparam int          ONE         = 65536;
    localparam logic [31:0] C_MIN       = 32'h8000_0000;
    localparam logic [31:0] C_MAX       = 32'h7fff_ffff;

    typedef struct packed {
        t_op         op;
        logic [30:0] radius;
        logic [31:0] hz;
        logic [31:0] hy;
        logic [31:0] hx;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } t_query;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [4:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;

    // Shadow copy of the box registers, signed.
    longint   box_lo[3];
    longint   box_hi[3];
    t_verdict expected_verdicts[$];
    int       error_count  = 0;
    int       idle_cycles  = 0;
    int       src_idle_pct = 30;
    int       sink_idle_pct = 46;

    aabb_region_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_verdict classify_query(t_query q);
        longint       lo[3];
        longint       hi[3];
        longint       rad;
        logic [127:0] dist2;
        logic [127:0] gap;
        bit           pt_out;
        bit           box_out;
        bit           reaches;
        t_verdict     v;
        lo[0] = $signed(q.x);
        lo[1] = $signed(q.y);
        lo[2] = $signed(q.z);
        hi[0] = $signed(q.hx);
        hi[1] = $signed(q.hy);
        hi[2] = $signed(q.hz);
        rad = longint'(q.radius);
        pt_out = 1'b0;
        box_out = 1'b0;
        reaches = 1'b0;
        dist2 = '0;
        for (int i = 0; i < 3; i++) begin
            if (lo[i] < box_lo[i] || lo[i] > box_hi[i]) pt_out = 1'b1;
            if (hi[i] < box_lo[i] || lo[i] > box_hi[i]) box_out = 1'b1;
        end
        case (q.op)
            OP_POINT: v = pt_out ? VERDICT_OUT : VERDICT_IN;
            OP_BOX: begin
                for (int i = 0; i < 3; i++)
                    if (lo[i] < box_lo[i] || hi[i] > box_hi[i]) reaches = 1'b1;
                v = box_out ? VERDICT_OUT : (reaches ? VERDICT_ISECT : VERDICT_IN);
            end
            OP_SPHERE: begin
                // Squared distances reach about 3 * 2^64, so they are summed in 128 bits.
                for (int i = 0; i < 3; i++) begin
                    if (lo[i] < box_lo[i])
                        gap = 128'(box_lo[i] - lo[i]);
                    else if (lo[i] > box_hi[i])
                        gap = 128'(lo[i] - box_hi[i]);
                    else
                        gap = '0;
                    dist2 = dist2 + gap * gap;
                    if (lo[i] - rad < box_lo[i] || lo[i] + rad > box_hi[i]) reaches = 1'b1;
                end
                if (dist2 > 128'(rad) * 128'(rad))
                    v = VERDICT_OUT;
                else
                    v = reaches ? VERDICT_ISECT : VERDICT_IN;
            end
            default: v = box_out ? VERDICT_OUT : VERDICT_IN;
        endcase
        return v;
    endfunction

    function automatic t_query make_query(t_op op, logic [31:0] x, y, z, hx, hy, hz,
                                          logic [30:0] rad);
        t_query q;
        q.op = op;
        q.x = x;
        q.y = y;
        q.z = z;
        q.hx = hx;
        q.hy = hy;
        q.hz = hz;
        q.radius = rad;
        return q;
    endfunction

    // Coordinates cluster around the box faces and center so that every
    // boundary comparison flips often; a few are fully random.
    function automatic logic [31:0] rand_coord(int axis);
        longint base;
        longint offs;
        case ($urandom_range(3))
            0:       base = box_lo[axis];
            1:       base = box_hi[axis];
            default: base = box_lo[axis] + (box_hi[axis] - box_lo[axis]) / 2;
        endcase
        case ($urandom_range(4))
            0:       offs = 0;
            1:       offs = longint'($urandom_range(12)) - 6;
            2, 3:    offs = (longint'($urandom_range(16)) - 8) * ONE;
            default: offs = longint'($urandom_range(1 << 22)) - (1 << 21);
        endcase
        if ($urandom_range(7) == 0)
            rand_coord = $urandom;
        else
            rand_coord = 32'(base + offs);
    endfunction

    function automatic logic [31:0] rand_upper(int axis, logic [31:0] lo);
        case ($urandom_range(3))
            0:       rand_upper = rand_coord(axis);
            1:       rand_upper = lo + 32'($urandom_range(6) * ONE);
            default: rand_upper = lo + 32'($urandom_range(1 << 18));
        endcase
    endfunction

    function automatic logic [30:0] rand_radius();
        case ($urandom_range(5))
            0:       rand_radius = '0;
            1:       rand_radius = 31'h7fff_ffff;
            2:       rand_radius = 31'($urandom);
            3, 4:    rand_radius = 31'($urandom_range(8) * ONE);
            default: rand_radius = 31'($urandom_range(1 << 22));
        endcase
    endfunction

    function automatic t_query rand_query();
        t_query q;
        q.op = t_op'($urandom_range(3));
        q.x = rand_coord(0);
        q.y = rand_coord(1);
        q.z = rand_coord(2);
        q.hx = rand_upper(0, q.x);
        q.hy = rand_upper(1, q.y);
        q.hz = rand_upper(2, q.z);
        q.radius = rand_radius();
        return q;
    endfunction

    task automatic send_query(t_query q);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, q.radius, q.hz, q.hy, q.hx, q.z, q.y, q.x};
        s_axis_tuser  <= q.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_verdicts.push_back(classify_query(q));
    endtask

    // Stops the request stream and waits until every verdict is back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_box_reg(t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx < REG_MAX_X)
            box_lo[idx] = $signed(val);
        else
            box_hi[idx - REG_MAX_X] = $signed(val);
    endtask

    task automatic set_box(logic [31:0] min_x, min_y, min_z, max_x, max_y, max_z);
        wait_for_results();
        repeat (PIPE_LAT + 2) @(posedge i_clk);
        write_box_reg(REG_MIN_X, min_x);
        write_box_reg(REG_MIN_Y, min_y);
        write_box_reg(REG_MIN_Z, min_z);
        write_box_reg(REG_MAX_X, max_x);
        write_box_reg(REG_MAX_Y, max_y);
        write_box_reg(REG_MAX_Z, max_z);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Kinds: 0 small grid box, 1 full range, 2 empty, 3 single point,
    // 4 one axis inverted, 5 raw random corners.
    task automatic set_random_box(int kind);
        logic [31:0] mn[3];
        logic [31:0] mx[3];
        int          ctr;
        int          half;
        int          flip;
        flip = $urandom_range(2);
        for (int i = 0; i < 3; i++) begin
            ctr  = (int'($urandom_range(40)) - 20) * ONE;
            half = int'($urandom_range(8)) * ONE;
            case (kind)
                1: begin
                    mn[i] = C_MIN;
                    mx[i] = C_MAX;
                end
                2: begin
                    mn[i] = C_MAX;
                    mx[i] = C_MIN;
                end
                3: begin
                    mn[i] = ctr;
                    mx[i] = ctr;
                end
                5: begin
                    mn[i] = $urandom;
                    mx[i] = $urandom;
                end
                default: begin
                    mn[i] = ctr - half;
                    mx[i] = ctr + half;
                    if (kind == 4 && i == flip) begin
                        mn[i] = ctr + half + ONE;
                        mx[i] = ctr - half;
                    end
                end
            endcase
        end
        set_box(mn[0], mn[1], mn[2], mx[0], mx[1], mx[2]);
    endtask

    // The box after reset is empty, so points never land inside.
    task automatic test_empty_box();
        send_query(make_query(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(OP_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0));
        send_query(make_query(OP_SPHERE, 0, 0, 0, 0, 0, 0, 31'h7fff_ffff));
        send_query(make_query(OP_FAST, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0));
    endtask

    task automatic test_point_queries();
        set_box(-2 * ONE, -ONE, 0, 2 * ONE, 3 * ONE, 4 * ONE);
        send_query(make_query(OP_POINT, 0, 0, ONE, $urandom, $urandom, $urandom, 0));
        send_query(make_query(OP_POINT, -2 * ONE, -ONE, 0, 0, 0, 0, 31'h7fff_ffff));
        send_query(make_query(OP_POINT, 2 * ONE, 3 * ONE, 4 * ONE, 0, 0, 0, 0));
        send_query(make_query(OP_POINT, 2 * ONE + 1, 0, ONE, 0, 0, 0, 0));
    endtask

    task automatic test_box_queries();
        send_query(make_query(OP_BOX, -ONE, 0, ONE, ONE, ONE, 2 * ONE, 0));
        send_query(make_query(OP_BOX, -3 * ONE, 0, ONE, 0, ONE, 2 * ONE, 0));
        send_query(make_query(OP_BOX, 3 * ONE, 0, ONE, 4 * ONE, ONE, 2 * ONE, 0));
        // Query box with lower corner above its upper corner on x.
        send_query(make_query(OP_BOX, ONE, 0, ONE, -ONE, ONE, 2 * ONE, 0));
    endtask

    task automatic test_sphere_queries();
        send_query(make_query(OP_SPHERE, 0, ONE, 2 * ONE, 0, 0, 0, 31'(ONE)));
        send_query(make_query(OP_SPHERE, 0, ONE, 2 * ONE, 0, 0, 0, 31'(3 * ONE)));
        // Center 3, 4 and 0 units off the box on x, y and z: distance exactly 5.
        send_query(make_query(OP_SPHERE, 5 * ONE, 7 * ONE, 2 * ONE, 0, 0, 0, 31'(5 * ONE)));
        send_query(make_query(OP_SPHERE, 5 * ONE, 7 * ONE, 2 * ONE, 0, 0, 0,
                              31'(5 * ONE - 1)));
        send_query(make_query(OP_SPHERE, 2 * ONE, 3 * ONE, 4 * ONE, 0, 0, 0, 0));
    endtask

    task automatic test_fast_overlap();
        send_query(make_query(OP_FAST, -3 * ONE, 0, ONE, 0, ONE, 2 * ONE, 0));
        send_query(make_query(OP_FAST, 3 * ONE, 0, ONE, 4 * ONE, ONE, 2 * ONE, 0));
        // Touching faces count as overlapping.
        send_query(make_query(OP_FAST, -4 * ONE, 0, ONE, -2 * ONE, ONE, 2 * ONE, 0));
    endtask

    task automatic test_extreme_values();
        set_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        send_query(make_query(OP_POINT, C_MIN, C_MAX, 0, 0, 0, 0, 0));
        send_query(make_query(OP_SPHERE, C_MIN, C_MIN, C_MIN, 0, 0, 0, 31'h7fff_ffff));
        set_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_query(make_query(OP_SPHERE, C_MIN, C_MIN, C_MIN, 0, 0, 0, 31'h7fff_ffff));
        send_query(make_query(OP_POINT, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0));
        send_query(make_query(OP_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0));
        send_query(make_query(OP_FAST, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 30 : ((phase == 1) ? 46 : 0);
            sink_idle_pct = (phase == 0) ? 46 : ((phase == 1) ? 30 : 0);
            for (int k = 0; k < 5; k++) begin
                set_random_box((k == 0 || k == 4) ? 0 : ((phase * 3 + k) % 5) + 1);
                for (int n = 0; n < 110; n++) begin
                    if ($urandom_range(199) == 0) wait_for_results();
                    send_query(rand_query());
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                $error("verdict: expected none, got %0d", m_axis_tdata[1:0]);
                error_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (m_axis_tdata[1:0] !== want) begin
                    $error("verdict: expected %0d, got %0d", want, m_axis_tdata[1:0]);
                    error_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < 3; i++) begin
            box_lo[i] = $signed(C_MAX);
            box_hi[i] = $signed(C_MIN);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_box();
        test_point_queries();
        test_box_queries();
        test_sphere_queries();
        test_fast_overlap();
        test_extreme_values();
        test_random_traffic();
        wait_for_results();
        repeat (2 * PIPE_LAT) @(posedge i_clk);
        if (error_count == 0 && expected_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
